FILE: rtl/bounding_box_transform_defines.svh
// assertion macros for the bounding box transform block
// used by files that check their own logic, needs clk and rst_n in scope
`ifndef BOUNDING_BOX_TRANSFORM_DEFINES_SVH
`define BOUNDING_BOX_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define BBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBT_ASSERT(lbl, prop, msg)
`define BBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/bbt_pkg.sv
// shared types, constants and helpers for the bounding box transform
// no dependencies
`default_nettype none
package bbt_pkg;
  localparam int FRAC_BITS = 16;
  localparam int TERM_W = 64 - FRAC_BITS;
  localparam int ACC_W = TERM_W + 2;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_POINT = 2'd1;
  localparam logic [1:0] FUNC_BOX = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [1:0] LAST_COL = 2'd2;
  localparam logic [1:0] LAST_BOX_ROW = 2'd2;
  localparam logic [1:0] LAST_PNT_ROW = 2'd3;
  localparam logic [2:0] LAST_TGT = 3'd5;
  localparam logic [2:0] FIRST_HI_TGT = 3'd3;
  localparam logic [4:0] LAST_BIT = 5'd31;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic signed [31:0] hi_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_lo_x;
    logic signed [31:0] res_lo_y;
    logic signed [31:0] res_lo_z;
    logic signed [31:0] res_hi_x;
    logic signed [31:0] res_hi_y;
    logic signed [31:0] res_hi_z;
    logic signed [31:0] res_w;
    logic zero_divisor;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic [1:0] row;
    logic [1:0] col;
    logic side;
    logic div_init;
    logic div_step;
    logic div_store;
    logic [2:0] tgt;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic w_zero;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(signed'(32'sh7fffffff))) r = 32'sh7fffffff;
    else if (v < ACC_W'(signed'(32'sh80000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/bbt_ctrl.sv
// sequencing state machine for the bounding box transform
// depends on bbt_pkg and bounding_box_transform_defines.svh
`include "bounding_box_transform_defines.svh"
`default_nettype none
module bbt_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] in_func,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire bbt_pkg::status_t status,
  output bbt_pkg::cmd_t cmd
);
  bbt_pkg::state_t state_r, state_nxt;
  logic box_r, box_nxt;
  logic [1:0] row_r, row_nxt, col_r, col_nxt;
  logic side_r, side_nxt;
  logic [2:0] tgt_r, tgt_nxt;
  logic [4:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbt_pkg::ST_IDLE;
      box_r <= 1'b0;
      row_r <= '0;
      col_r <= '0;
      side_r <= 1'b0;
      tgt_r <= '0;
      bit_r <= '0;
    end else begin
      state_r <= state_nxt;
      box_r <= box_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      side_r <= side_nxt;
      tgt_r <= tgt_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    box_nxt = box_r;
    row_nxt = row_r;
    col_nxt = col_r;
    side_nxt = side_r;
    tgt_nxt = tgt_r;
    bit_nxt = bit_r;
    case (state_r)
      bbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          box_nxt = (in_func == bbt_pkg::FUNC_BOX);
          row_nxt = '0;
          col_nxt = '0;
          side_nxt = 1'b0;
          tgt_nxt = '0;
          if (in_func == bbt_pkg::FUNC_POINT) state_nxt = bbt_pkg::ST_MUL;
          else if (in_func == bbt_pkg::FUNC_BOX && !status.w_zero)
            state_nxt = bbt_pkg::ST_MUL;
          else state_nxt = bbt_pkg::ST_FIN;
        end
      end
      bbt_pkg::ST_MUL: begin
        if (box_r && !side_r) begin
          side_nxt = 1'b1;
        end else begin
          side_nxt = 1'b0;
          if (col_r == bbt_pkg::LAST_COL) begin
            col_nxt = '0;
            row_nxt = row_r + 2'd1;
            if ((box_r && row_r == bbt_pkg::LAST_BOX_ROW) ||
                (!box_r && row_r == bbt_pkg::LAST_PNT_ROW))
              state_nxt = bbt_pkg::ST_DRAIN;
          end else begin
            col_nxt = col_r + 2'd1;
          end
        end
      end
      bbt_pkg::ST_DRAIN: begin
        state_nxt = box_r ? bbt_pkg::ST_DIV_INIT : bbt_pkg::ST_FIN;
      end
      bbt_pkg::ST_DIV_INIT: begin
        bit_nxt = '0;
        state_nxt = bbt_pkg::ST_DIV_STEP;
      end
      bbt_pkg::ST_DIV_STEP: begin
        bit_nxt = bit_r + 5'd1;
        if (bit_r == bbt_pkg::LAST_BIT) state_nxt = bbt_pkg::ST_DIV_STORE;
      end
      bbt_pkg::ST_DIV_STORE: begin
        if (tgt_r == bbt_pkg::LAST_TGT) begin
          state_nxt = bbt_pkg::ST_FIN;
        end else begin
          tgt_nxt = tgt_r + 3'd1;
          state_nxt = bbt_pkg::ST_DIV_INIT;
        end
      end
      bbt_pkg::ST_FIN: begin
        state_nxt = bbt_pkg::ST_OUT;
      end
      bbt_pkg::ST_OUT: begin
        if (out_ready) state_nxt = bbt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.row = row_r;
    cmd.col = col_r;
    cmd.side = side_r;
    cmd.tgt = tgt_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      bbt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bbt_pkg::ST_MUL: cmd.mul = 1'b1;
      bbt_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      bbt_pkg::ST_DIV_STEP: cmd.div_step = 1'b1;
      bbt_pkg::ST_DIV_STORE: cmd.div_store = 1'b1;
      bbt_pkg::ST_FIN: cmd.fin = 1'b1;
      bbt_pkg::ST_OUT: out_valid = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `BBT_ASSERT(a_no_overlap, !(in_ready && out_valid), "request taken while result pending")
  `BBT_ASSERT(a_load_on_accept, cmd.load |-> (in_valid && in_ready), "load without request")
  `BBT_ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> (state_r == bbt_pkg::ST_IDLE),
    "not idle after reset")
  `BBT_ASSERT(a_fin_then_out, cmd.fin |=> out_valid, "finish did not present result")
endmodule
`default_nettype wire

FILE: rtl/bbt_dp.sv
// matrix store, shared multiplier, accumulators and serial divider
// depends on bbt_pkg
`default_nettype none
module bbt_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire bbt_pkg::in_t in_data,
  input  wire bbt_pkg::cmd_t cmd,
  output bbt_pkg::status_t status,
  output bbt_pkg::out_t out_data
);
  localparam int AW = bbt_pkg::ACC_W;
  localparam int FB = bbt_pkg::FRAC_BITS;
  localparam int TW = bbt_pkg::TERM_W;

  logic signed [31:0] mat_r [16];
  bbt_pkg::in_t in_r;
  logic [1:0] func_r;
  logic signed [63:0] p_r;
  logic pv_r, pside_r;
  logic [1:0] prow_r;
  logic signed [TW-1:0] a_r;
  logic signed [AW-1:0] acc_lo_r [4];
  logic signed [AW-1:0] acc_hi_r [4];
  logic [31:0] rem_r, dl_r, q_r, d_r;
  logic neg_r, ovf_r;
  bbt_pkg::out_t res_r;

  logic signed [31:0] opnd, mel;
  logic signed [63:0] shifted;
  logic signed [TW-1:0] term, tmin, tmax;
  logic [1:0] aidx;
  logic signed [AW-1:0] num;
  logic [AW-1:0] nabs;
  logic [32:0] rem2;
  logic [31:0] qsat, qres;

  assign status.w_zero = (mat_r[15] == 32'sd0);
  assign out_data = res_r;

  always_comb begin
    case (cmd.col)
      2'd0: opnd = cmd.side ? in_r.hi_x : in_r.lo_x;
      2'd1: opnd = cmd.side ? in_r.hi_y : in_r.lo_y;
      default: opnd = cmd.side ? in_r.hi_z : in_r.lo_z;
    endcase
    mel = mat_r[{cmd.row, cmd.col}];
    shifted = p_r >>> FB;
    term = shifted[TW-1:0];
    tmin = (a_r < term) ? a_r : term;
    tmax = (a_r < term) ? term : a_r;
    aidx = (cmd.tgt >= bbt_pkg::FIRST_HI_TGT) ? 2'(cmd.tgt - bbt_pkg::FIRST_HI_TGT)
                                               : cmd.tgt[1:0];
    num = (cmd.tgt >= bbt_pkg::FIRST_HI_TGT) ? acc_hi_r[aidx] : acc_lo_r[aidx];
    nabs = num[AW-1] ? AW'(-num) : AW'(num);
    rem2 = {rem_r, dl_r[31]};
    qsat = ovf_r ? 32'h7fffffff : q_r;
    if (neg_r) qsat = (ovf_r || q_r > 32'h80000000) ? 32'h80000000 : q_r;
    else if (q_r > 32'h7fffffff) qsat = 32'h7fffffff;
    qres = neg_r ? 32'(-qsat) : qsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) begin
        mat_r[k] <= (k % 5 == 0) ? 32'(1 << FB) : 32'sd0;
      end
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul;
      if (cmd.load && in_data.func == bbt_pkg::FUNC_WRITE)
        mat_r[in_data.elem_index] <= in_data.elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
      func_r <= in_data.func;
      res_r <= '0;
      for (int i = 0; i < 4; i++) begin
        acc_lo_r[i] <= AW'(mat_r[i*4+3]);
        acc_hi_r[i] <= AW'(mat_r[i*4+3]);
      end
    end
    p_r <= mel * opnd;
    prow_r <= cmd.row;
    pside_r <= cmd.side;
    if (pv_r) begin
      if (func_r != bbt_pkg::FUNC_BOX) begin
        acc_lo_r[prow_r] <= acc_lo_r[prow_r] + AW'(term);
      end else if (!pside_r) begin
        a_r <= term;
      end else begin
        acc_lo_r[prow_r] <= acc_lo_r[prow_r] + AW'(tmin);
        acc_hi_r[prow_r] <= acc_hi_r[prow_r] + AW'(tmax);
      end
    end
    if (cmd.div_init) begin
      d_r <= mat_r[15][31] ? 32'(-mat_r[15]) : 32'(mat_r[15]);
      neg_r <= num[AW-1] != mat_r[15][31];
      ovf_r <= nabs >= AW'({mat_r[15][31] ? 32'(-mat_r[15]) : 32'(mat_r[15]),
                            {(32-FB){1'b0}}});
      rem_r <= nabs[(32-FB)+31:(32-FB)];
      dl_r <= {nabs[31-FB:0], {FB{1'b0}}};
      q_r <= '0;
    end
    if (cmd.div_step) begin
      dl_r <= {dl_r[30:0], 1'b0};
      if (rem2 >= {1'b0, d_r}) begin
        rem_r <= 32'(rem2 - {1'b0, d_r});
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rem2[31:0];
        q_r <= {q_r[30:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      case (cmd.tgt)
        3'd0: res_r.res_lo_x <= qres;
        3'd1: res_r.res_lo_y <= qres;
        3'd2: res_r.res_lo_z <= qres;
        3'd3: res_r.res_hi_x <= qres;
        3'd4: res_r.res_hi_y <= qres;
        default: res_r.res_hi_z <= qres;
      endcase
    end
    if (cmd.fin) begin
      if (func_r == bbt_pkg::FUNC_POINT) begin
        res_r.res_lo_x <= bbt_pkg::sat32(acc_lo_r[0]);
        res_r.res_lo_y <= bbt_pkg::sat32(acc_lo_r[1]);
        res_r.res_lo_z <= bbt_pkg::sat32(acc_lo_r[2]);
        res_r.res_w <= bbt_pkg::sat32(acc_lo_r[3]);
      end else if (func_r == bbt_pkg::FUNC_BOX) begin
        res_r.res_w <= mat_r[15];
        res_r.zero_divisor <= status.w_zero;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bounding_box_transform.sv
// 4x4 transform of points and boxes in signed Q16.16, top level
// a write or unknown function goes straight to the result; a point takes the multiply pass,
// a box the multiply and divide passes (a box with a zero divisor goes straight to the result)
// one request at a time; the shared multiplier and the 1-bit-per-cycle divider set the rate
// synchronous active-low reset restores the identity matrix and idles the block
`default_nettype none
module bounding_box_transform (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire bbt_pkg::in_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output bbt_pkg::out_t out_data
);
  bbt_pkg::cmd_t cmd;
  bbt_pkg::status_t status;

  bbt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_data.func), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  bbt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
    .status(status), .out_data(out_data)
  );
endmodule
`default_nettype wire
